[rtl/core/mtt_pkg.sv]
// shared constants and types for the move toward target step block
package mtt_pkg;
  localparam logic [1:0] CMD_UPDATE  = 2'd0;
  localparam logic [1:0] CMD_PREVIEW = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  localparam logic [2:0] REG_START_X  = 3'd0;
  localparam logic [2:0] REG_START_Y  = 3'd1;
  localparam logic [2:0] REG_TARGET_X = 3'd2;
  localparam logic [2:0] REG_TARGET_Y = 3'd3;
  localparam logic [2:0] REG_SPEED    = 3'd4;

  localparam int unsigned US_PER_SEC = 1000000;
  localparam int STEP_W = 33;
  localparam int SQ_W = 67;
  localparam int PROD_W = 66;

  // shared divider request
  typedef struct packed {
    logic             start;
    logic [PROD_W-1:0] num;
    logic [63:0]       den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;
endpackage

[rtl/core/mtt_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
module mtt_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mtt_pkg::div_req_t req,
  output mtt_pkg::div_rsp_t rsp
);
  localparam int NW = mtt_pkg::PROD_W;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r;
  logic [64:0]   rem_r;
  logic [63:0]   den_r;
  logic [63:0]   quo_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [64:0]   sh;
  logic          ge;

  // shift in one numerator bit and trial subtract
  always_comb begin
    sh = {rem_r[63:0], num_r[NW-1]};
    ge = sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        num_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        quo_r  <= '0;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        rem_r <= ge ? sh - {1'b0, den_r} : sh;
        quo_r <= {quo_r[62:0], ge};
        num_r <= {num_r[NW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule

[rtl/core/move_toward_target_step.sv]
// top level: steps a point toward a destination, one tick per transaction
// usage:
//   cfg_valid/cfg_ready/cfg_index/cfg_data write start, target and speed
//   registers; write them only while the block is idle.
//   in_command/in_elapsed_us enter on the input channel, one transaction at a
//   time; each gives exactly one result on out_pos_x/out_pos_y/out_arrived.
// flow: restart and unused codes go from idle straight to the output state. a
//   snap needs the step divide by one million and the squares; a partial move
//   adds the 34-step square root at two radicand bits a cycle, then two axis
//   divides, all through one shared divider that retires one quotient bit per
//   cycle, and the squares and products come from a shift-and-add unit at one
//   bit a cycle.
// input: the next input is taken in the cycle after the result is loaded, so
//   one transaction is in work at a time; a new input is taken while the
//   previous result waits in the output register.
// reset: registers, position and arrived flag clear to zero.
// stall: the result holds on the out channel until out_ready is high; the
//   next computation may finish meanwhile but waits before overwriting it.
module move_toward_target_step #(
  parameter int TIME_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [19:0] in_elapsed_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic        out_arrived
);
  localparam int TW = (TIME_BITS < 20) ? TIME_BITS : 20;
  localparam int MW = 66;
  localparam int unsigned US_PER_SEC_C = mtt_pkg::US_PER_SEC;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_STEPD = 4'd1;
  localparam logic [3:0] S_SQX   = 4'd2;
  localparam logic [3:0] S_SQY   = 4'd3;
  localparam logic [3:0] S_SS    = 4'd4;
  localparam logic [3:0] S_ROOT  = 4'd5;
  localparam logic [3:0] S_PX    = 4'd6;
  localparam logic [3:0] S_DX    = 4'd7;
  localparam logic [3:0] S_PY    = 4'd8;
  localparam logic [3:0] S_DY    = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_MUL0  = 4'd11;
  localparam logic [3:0] S_DIV0  = 4'd12;

  logic [31:0] start_x_r, start_y_r, target_x_r, target_y_r, speed_r;
  logic [31:0] cur_x_r, cur_y_r;
  logic        done_r;
  logic [3:0]  state_r, ret_r;
  logic [1:0]  cmd_r;
  logic [32:0] step_r, ax_r, ay_r, dist_r;
  logic        sx_r, sy_r;
  logic [MW:0] sq_r;
  logic [65:0] sqx_r;
  logic [31:0] mvx_r;
  logic [31:0] res_x_r, res_y_r;
  logic        res_arr_r, res_commit_r;
  logic        ov_r;
  logic [31:0] ox_r, oy_r;
  logic        oa_r;
  logic [5:0]  bit_r;

  // digit-by-digit square root: radicand shifter and partial remainder
  logic [67:0] rad_r;
  logic [33:0] rrem_r;
  logic [35:0] rrem_nxt;

  // shift-and-add multiplier, one multiplier bit a cycle
  logic [65:0] ma_r, macc_r;
  logic [32:0] mb_r;
  logic [5:0]  mcnt_r;

  mtt_pkg::div_req_t dreq;
  mtt_pkg::div_rsp_t drsp;

  mtt_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic signed [32:0] dxs, dys;
  logic [35:0] rsh;
  logic [35:0] rtrial;
  logic        rge;
  logic [63:0] qsat;
  logic [32:0] step_sat;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_pos_x = ox_r;
  assign out_pos_y = oy_r;
  assign out_arrived = oa_r;

  // deltas, square root trial and divider request
  always_comb begin
    dxs = $signed({target_x_r[31], target_x_r}) - $signed({cur_x_r[31], cur_x_r});
    dys = $signed({target_y_r[31], target_y_r}) - $signed({cur_y_r[31], cur_y_r});
    rsh = {rrem_r, rad_r[67:66]};
    rtrial = {1'b0, dist_r, 2'b01};
    rge = (rsh >= rtrial);
    rrem_nxt = rge ? rsh - rtrial : rsh;
    qsat = drsp.quo;
    step_sat = (qsat > 64'h1_FFFF_FFFF) ? 33'h1_FFFF_FFFF : qsat[32:0];
    dreq.start = 1'b0;
    dreq.num = '0;
    dreq.den = 64'd1;
    if (state_r == S_DIV0) begin
      dreq.start = 1'b1;
      if (ret_r == S_STEPD) begin
        dreq.num = macc_r;
        dreq.den = 64'(US_PER_SEC_C);
      end else begin
        dreq.num = macc_r;
        dreq.den = 64'(dist_r);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0; start_y_r <= '0; target_x_r <= '0;
      target_y_r <= '0; speed_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mtt_pkg::REG_START_X:  start_x_r  <= cfg_data;
        mtt_pkg::REG_START_Y:  start_y_r  <= cfg_data;
        mtt_pkg::REG_TARGET_X: target_x_r <= cfg_data;
        mtt_pkg::REG_TARGET_Y: target_y_r <= cfg_data;
        mtt_pkg::REG_SPEED:    speed_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ret_r <= S_IDLE;
      cur_x_r <= '0; cur_y_r <= '0; done_r <= 1'b0;
      ov_r <= 1'b0; mcnt_r <= '0; bit_r <= '0;
    end else begin
      if (ov_r && out_ready && state_r != S_OUT) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid) begin
          cmd_r <= in_command;
          res_commit_r <= 1'b0;
          if (in_command == mtt_pkg::CMD_RESTART) begin
            cur_x_r <= start_x_r; cur_y_r <= start_y_r; done_r <= 1'b0;
            res_x_r <= start_x_r; res_y_r <= start_y_r; res_arr_r <= 1'b0;
            state_r <= S_OUT;
          end else if (in_command == mtt_pkg::CMD_UPDATE ||
                       in_command == mtt_pkg::CMD_PREVIEW) begin
            ax_r <= dxs[32] ? 33'(-dxs) : 33'(dxs);
            ay_r <= dys[32] ? 33'(-dys) : 33'(dys);
            sx_r <= dxs[32]; sy_r <= dys[32];
            ma_r <= 66'(speed_r);
            mb_r <= 33'(in_elapsed_us[TW-1:0]);
            macc_r <= '0; mcnt_r <= 6'd33;
            ret_r <= S_STEPD; state_r <= S_MUL0;
          end else begin
            res_x_r <= cur_x_r; res_y_r <= cur_y_r; res_arr_r <= done_r;
            state_r <= S_OUT;
          end
        end
        S_MUL0: begin
          if (mb_r[0]) macc_r <= macc_r + ma_r;
          ma_r <= {ma_r[64:0], 1'b0};
          mb_r <= {1'b0, mb_r[32:1]};
          mcnt_r <= mcnt_r - 1'b1;
          if (mcnt_r == 6'd1) state_r <= (ret_r == S_STEPD || ret_r == S_DX ||
                                          ret_r == S_DY) ? S_DIV0 : ret_r;
        end
        S_DIV0: state_r <= ret_r;
        S_STEPD: if (drsp.done) begin
          step_r <= step_sat;
          ma_r <= 66'(ax_r); mb_r <= ax_r; macc_r <= '0; mcnt_r <= 6'd33;
          ret_r <= S_SQX; state_r <= S_MUL0;
        end
        S_SQX: begin
          sqx_r <= macc_r;
          ma_r <= 66'(ay_r); mb_r <= ay_r; macc_r <= '0; mcnt_r <= 6'd33;
          ret_r <= S_SQY; state_r <= S_MUL0;
        end
        S_SQY: begin
          sq_r <= {1'b0, sqx_r} + {1'b0, macc_r};
          ma_r <= 66'(step_r); mb_r <= step_r; macc_r <= '0; mcnt_r <= 6'd33;
          ret_r <= S_SS; state_r <= S_MUL0;
        end
        S_SS: begin
          if (sq_r <= {1'b0, macc_r}) begin
            res_x_r <= target_x_r; res_y_r <= target_y_r; res_arr_r <= 1'b1;
            res_commit_r <= (cmd_r == mtt_pkg::CMD_UPDATE);
            state_r <= S_OUT;
          end else begin
            dist_r <= '0; rrem_r <= '0; rad_r <= {1'b0, sq_r};
            bit_r <= 6'd33; state_r <= S_ROOT;
          end
        end
        // one root bit per cycle from two radicand bits
        S_ROOT: begin
          rad_r <= {rad_r[65:0], 2'b00};
          rrem_r <= rrem_nxt[33:0];
          dist_r <= {dist_r[31:0], rge};
          if (bit_r == 6'd0) state_r <= S_PX;
          else bit_r <= bit_r - 1'b1;
        end
        S_PX: begin
          ma_r <= 66'(step_r); mb_r <= ax_r; macc_r <= '0; mcnt_r <= 6'd33;
          ret_r <= S_DX; state_r <= S_MUL0;
        end
        S_DX: if (drsp.done) begin
          mvx_r <= drsp.quo[31:0];
          ma_r <= 66'(step_r); mb_r <= ay_r; macc_r <= '0; mcnt_r <= 6'd33;
          ret_r <= S_DY; state_r <= S_MUL0;
        end
        S_DY: if (drsp.done) begin
          res_x_r <= sx_r ? cur_x_r - mvx_r : cur_x_r + mvx_r;
          res_y_r <= sy_r ? cur_y_r - drsp.quo[31:0] : cur_y_r + drsp.quo[31:0];
          res_arr_r <= 1'b0;
          res_commit_r <= (cmd_r == mtt_pkg::CMD_UPDATE);
          state_r <= S_OUT;
        end
        S_OUT: if (!ov_r || out_ready) begin
          ov_r <= 1'b1;
          ox_r <= res_x_r; oy_r <= res_y_r; oa_r <= res_arr_r;
          if (res_commit_r) begin
            cur_x_r <= res_x_r; cur_y_r <= res_y_r; done_r <= res_arr_r;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[sim/move_toward_target_step_tb.sv]
// testbench for the move toward target step block: predictor, driver and monitor
`timescale 1ns / 100ps

module move_toward_target_step_tb;

  typedef struct {
    logic [1:0]  command;
    logic [19:0] elapsed_us;
  } tick_t;

  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic        arrived;
  } pos_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic [19:0] in_elapsed_us;
  logic        out_valid;
  logic        out_ready;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic        out_arrived;

  // predictor copy of registers and state
  logic [31:0] m_start_x, m_start_y, m_target_x, m_target_y, m_speed;
  logic [31:0] m_cur_x, m_cur_y;
  logic        m_done;

  tick_t tick_q[$];
  pos_t  pos_expect_q[$];
  int    err_count;
  int    send_idle_pct;
  int    recv_stall_pct;

  move_toward_target_step i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_elapsed_us(in_elapsed_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_arrived(out_arrived)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // floor square root of a value below 2^67
  function automatic logic [33:0] isqrt(input logic [66:0] n);
    logic [33:0]  r;
    logic [33:0]  c;
    logic [67:0]  cc;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      cc = c * c;
      if (cc <= {1'b0, n}) r = c;
    end
    return r;
  endfunction

  // signed displacement along one axis
  function automatic logic signed [34:0] axis_step(input logic [32:0] step,
      input logic signed [33:0] d, input logic [33:0] root_v);
    logic [33:0] mag;
    logic [66:0] prod;
    logic [66:0] m;
    mag = d[33] ? 34'(-d) : 34'(d);
    prod = step * mag;
    m = prod / root_v;
    return d[33] ? -$signed({2'b00, m[32:0]}) : $signed({2'b00, m[32:0]});
  endfunction

  // next position for one tick, updating state as the command says
  function automatic pos_t move_point(input tick_t t);
    pos_t r;
    logic [52:0] raw;
    logic [32:0] step;
    logic signed [33:0] dx, dy;
    logic [33:0] ax, ay;
    logic [67:0] sq, ss;
    logic [33:0] root_v;
    r.pos_x = m_cur_x;
    r.pos_y = m_cur_y;
    r.arrived = m_done;
    if (t.command == mtt_pkg::CMD_RESTART) begin
      m_cur_x = m_start_x;
      m_cur_y = m_start_y;
      m_done = 1'b0;
      r.pos_x = m_start_x;
      r.pos_y = m_start_y;
      r.arrived = 1'b0;
    end else if (t.command == mtt_pkg::CMD_UPDATE || t.command == mtt_pkg::CMD_PREVIEW) begin
      raw = (m_speed * 53'(t.elapsed_us)) / 53'(mtt_pkg::US_PER_SEC);
      step = (raw > 53'h1_FFFF_FFFF) ? 33'h1_FFFF_FFFF : raw[32:0];
      dx = $signed({m_target_x[31], m_target_x}) - $signed({m_cur_x[31], m_cur_x});
      dy = $signed({m_target_y[31], m_target_y}) - $signed({m_cur_y[31], m_cur_y});
      ax = dx[33] ? 34'(-dx) : 34'(dx);
      ay = dy[33] ? 34'(-dy) : 34'(dy);
      sq = ax * ax + ay * ay;
      ss = step * step;
      if (sq <= ss) begin
        r.pos_x = m_target_x;
        r.pos_y = m_target_y;
        r.arrived = 1'b1;
      end else begin
        root_v = isqrt(sq[66:0]);
        if (root_v == 0) root_v = 1;
        r.pos_x = 32'($signed({m_cur_x[31], m_cur_x}) + axis_step(step, dx, root_v));
        r.pos_y = 32'($signed({m_cur_y[31], m_cur_y}) + axis_step(step, dy, root_v));
        r.arrived = 1'b0;
      end
      if (t.command == mtt_pkg::CMD_UPDATE) begin
        m_cur_x = r.pos_x;
        m_cur_y = r.pos_y;
        m_done = r.arrived;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
      input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    err_count++;
  endtask

  // driver: one tick transaction at a time from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        tick_t t;
        t = tick_q.pop_front();
        pos_expect_q.push_back(move_point(t));
        in_valid <= 1'b1;
        in_command <= t.command;
        in_elapsed_us <= t.elapsed_us;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pos_expect_q.size() == 0) begin
        $display("unexpected result transaction at %0t", $time);
        err_count++;
      end else begin
        pos_t e;
        e = pos_expect_q.pop_front();
        if (out_pos_x !== e.pos_x) report_mismatch("pos_x", out_pos_x, e.pos_x);
        if (out_pos_y !== e.pos_y) report_mismatch("pos_y", out_pos_y, e.pos_y);
        if (out_arrived !== e.arrived) report_mismatch("arrived", out_arrived, e.arrived);
      end
    end
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic drain();
    while (tick_q.size() > 0 || in_valid || pos_expect_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // one register write; the task then drops cfg_valid and idles the config channel before returning
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      mtt_pkg::REG_START_X:  m_start_x = val;
      mtt_pkg::REG_START_Y:  m_start_y = val;
      mtt_pkg::REG_TARGET_X: m_target_x = val;
      mtt_pkg::REG_TARGET_Y: m_target_y = val;
      mtt_pkg::REG_SPEED:    m_speed = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic add_tick(input logic [1:0] c, input logic [19:0] us);
    tick_t t;
    t.command = c;
    t.elapsed_us = us;
    tick_q.push_back(t);
  endtask

  // random coordinate: mostly moderate, sometimes extreme
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(2000000)) - 1000000) <<< 4;
    endcase
  endfunction

  initial begin
    int p;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_command = '0;
    in_elapsed_us = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    err_count = 0;
    m_start_x = 0; m_start_y = 0; m_target_x = 0; m_target_y = 0; m_speed = 0;
    m_cur_x = 0; m_cur_y = 0; m_done = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: at destination with zero speed, unused code, then extremes
    add_tick(mtt_pkg::CMD_UPDATE, 20'd0);
    add_tick(mtt_pkg::CMD_UNUSED, 20'hFFFFF);
    drain();
    write_reg(mtt_pkg::REG_START_X, 32'h8000_0000);
    write_reg(mtt_pkg::REG_START_Y, 32'h7FFF_FFFF);
    write_reg(mtt_pkg::REG_TARGET_X, 32'h7FFF_FFFF);
    write_reg(mtt_pkg::REG_TARGET_Y, 32'h8000_0000);
    write_reg(mtt_pkg::REG_SPEED, 32'd0);
    add_tick(mtt_pkg::CMD_RESTART, 20'd5);
    add_tick(mtt_pkg::CMD_UPDATE, 20'hFFFFF);
    add_tick(mtt_pkg::CMD_UNUSED, 20'd0);
    drain();
    write_reg(mtt_pkg::REG_SPEED, 32'hFFFF_FFFF);
    add_tick(mtt_pkg::CMD_UPDATE, 20'd0);
    add_tick(mtt_pkg::CMD_PREVIEW, 20'd1);
    add_tick(mtt_pkg::CMD_PREVIEW, 20'hFFFFF);
    add_tick(mtt_pkg::CMD_UPDATE, 20'd1000);
    add_tick(mtt_pkg::CMD_UPDATE, 20'hFFFFF);
    add_tick(mtt_pkg::CMD_UNUSED, 20'h5);
    add_tick(mtt_pkg::CMD_RESTART, 20'hAAAAA);
    drain();
    // restart onto the destination still reports not arrived
    write_reg(mtt_pkg::REG_START_X, 32'h7FFF_FFFF);
    write_reg(mtt_pkg::REG_START_Y, 32'h8000_0000);
    add_tick(mtt_pkg::CMD_RESTART, 20'h55555);
    add_tick(mtt_pkg::CMD_UPDATE, 20'd0);
    drain();

    // random phases: no idling, sender idle, receiver stall, both light
    for (p = 0; p < 24; p++) begin
      send_idle_pct = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 3) ? 8 : 45) : 0;
      recv_stall_pct = (p % 4 == 2) ? 45 : ((p % 4 == 3) ? 8 : 0);
      write_reg(mtt_pkg::REG_START_X, rand_coord());
      write_reg(mtt_pkg::REG_START_Y, rand_coord());
      write_reg(mtt_pkg::REG_TARGET_X, rand_coord());
      write_reg(mtt_pkg::REG_TARGET_Y, rand_coord());
      case (p % 3)
        0: write_reg(mtt_pkg::REG_SPEED, $urandom());
        1: write_reg(mtt_pkg::REG_SPEED, $urandom_range(32'h0400_0000));
        default: write_reg(mtt_pkg::REG_SPEED, (p == 5) ? 32'd0 : 32'hFFFF_FFFF);
      endcase
      add_tick(mtt_pkg::CMD_RESTART, 20'($urandom()));
      for (int k = 0; k < 68; k++) begin
        int r;
        r = $urandom_range(99);
        if (r < 60) add_tick(mtt_pkg::CMD_UPDATE,
                             (r < 20) ? 20'($urandom()) : 20'($urandom_range(50000)));
        else if (r < 85) add_tick(mtt_pkg::CMD_PREVIEW, 20'($urandom()));
        else if (r < 95) add_tick(mtt_pkg::CMD_RESTART, 20'($urandom()));
        else add_tick(mtt_pkg::CMD_UNUSED, 20'($urandom()));
      end
      drain();
    end

    if (err_count == 0) begin
      $display("move_toward_target_step verification clean");
    end else begin
      $display("move_toward_target_step verification failed");
    end
    $finish;
  end

  // run time limit
  initial begin
    #(20 * 6000000);
    $display("move_toward_target_step verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/core/mtt_pkg.sv
rtl/core/mtt_div.sv
rtl/core/move_toward_target_step.sv
sim/move_toward_target_step_tb.sv
